### sv/lpr_pkg.sv
// Shared constants for the line pixel rasterizer.
package lpr_pkg;

    // Default coordinate width, in bits per axis
    localparam int COORD_BITS_DEF = 6;
    // Color word width (24-bit RGB)
    localparam int COLOR_BITS = 24;

    // Sequencer state codes
    localparam logic LPR_IDLE = 1'b0;
    localparam logic LPR_RUN  = 1'b1;

endpackage

### sv/line_pixel_rasterizer_top.sv
// Line rasterizer: takes one line word and emits its pixels with an incremental error term.
//
//  channel | dir | handshake          | word
//  --------+-----+--------------------+----------------------------------------------
//  s_      | in  | s_valid / s_ready  | x_start, y_start, x_end, y_end, line_color
//  m_      | out | m_valid / m_ready  | pixel_x, pixel_y, pixel_color, last_pixel
//
// A line of n pixels, where n = max(|dx|, |dy|) + 1, is set up in the accept cycle;
// the error-term unit then gives one pixel per cycle while m_ready is high.
// The single add/compare/subtract unit steps the error term once per accepted pixel.
// s_ready is high only while no line is in flight; m_ready low holds the current pixel.
// aresetn is synchronous, active low, and returns the sequencer to idle.
module line_pixel_rasterizer_top
    import lpr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // input line channel
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [COORD_BITS-1:0] s_x_start,
    input  logic [COORD_BITS-1:0] s_y_start,
    input  logic [COORD_BITS-1:0] s_x_end,
    input  logic [COORD_BITS-1:0] s_y_end,
    input  logic [COLOR_BITS-1:0] s_line_color,
    // output pixel channel
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [COORD_BITS-1:0] m_pixel_x,
    output logic [COORD_BITS-1:0] m_pixel_y,
    output logic [COLOR_BITS-1:0] m_pixel_color,
    output logic                  m_last_pixel
);

    localparam int CW = COORD_BITS;

    logic          state_reg, state_next;
    logic [CW-1:0] px_reg, px_next;
    logic [CW-1:0] py_reg, py_next;
    logic [CW-1:0] err_reg, err_next;
    logic [CW-1:0] num_reg, num_next;
    logic [CW-1:0] den_reg, den_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          steep_reg, steep_next;
    logic          fall_reg, fall_next;
    logic [COLOR_BITS-1:0] color_reg, color_next;

    logic          s_acc, m_acc;
    logic          swap, fall, steep;
    logic [CW-1:0] xa, ya, xb, yb, dx, ady, lo;
    logic [CW:0]   sum;
    logic          carry;
    logic [CW-1:0] err_step, minor_step;

    assign s_acc = s_valid && s_ready;
    assign m_acc = m_valid && m_ready;

    // Setup: order endpoints so x rises, classify the slope
    always_comb begin
        swap  = s_x_end < s_x_start;
        xa    = swap ? s_x_end   : s_x_start;
        ya    = swap ? s_y_end   : s_y_start;
        xb    = swap ? s_x_start : s_x_end;
        yb    = swap ? s_y_start : s_y_end;
        dx    = xb - xa;
        fall  = yb < ya;
        ady   = fall ? (ya - yb) : (yb - ya);
        lo    = fall ? yb : ya;
        steep = ady > dx;
    end

    // Shared error-term unit: err + num, compare against den, subtract on carry
    always_comb begin
        sum        = {1'b0, err_reg} + {1'b0, num_reg};
        carry      = sum >= {1'b0, den_reg};
        err_step   = carry ? CW'(sum - {1'b0, den_reg}) : CW'(sum);
        minor_step = steep_reg ? px_reg : py_reg;
        if (carry) begin
            minor_step = fall_reg ? (minor_step - CW'(1)) : (minor_step + CW'(1));
        end
    end

    // Sequencer and datapath next state
    always_comb begin
        state_next = state_reg;
        px_next    = px_reg;
        py_next    = py_reg;
        err_next   = err_reg;
        num_next   = num_reg;
        den_next   = den_reg;
        cnt_next   = cnt_reg;
        steep_next = steep_reg;
        fall_next  = fall_reg;
        color_next = color_reg;
        case (state_reg)
            LPR_IDLE: begin
                if (s_acc) begin
                    state_next = LPR_RUN;
                    steep_next = steep;
                    fall_next  = fall;
                    color_next = s_line_color;
                    if (steep) begin
                        // step y upward; x offset is floor, or ceil back from xb
                        px_next  = fall ? xb : xa;
                        py_next  = lo;
                        num_next = dx;
                        den_next = ady;
                        err_next = fall ? (ady - CW'(1)) : '0;
                        cnt_next = ady;
                    end else begin
                        // step x; falling lines use ceil via a biased error term
                        px_next  = xa;
                        py_next  = ya;
                        num_next = ady;
                        den_next = dx;
                        err_next = fall ? (dx - CW'(1)) : '0;
                        cnt_next = dx;
                    end
                end
            end
            LPR_RUN: begin
                if (m_acc) begin
                    if (cnt_reg == '0) begin
                        state_next = LPR_IDLE;
                    end else begin
                        cnt_next = cnt_reg - CW'(1);
                        err_next = err_step;
                        if (steep_reg) begin
                            py_next = py_reg + CW'(1);
                            px_next = minor_step;
                        end else begin
                            px_next = px_reg + CW'(1);
                            py_next = minor_step;
                        end
                    end
                end
            end
            default: begin
                state_next = LPR_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= LPR_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        px_reg    <= px_next;
        py_reg    <= py_next;
        err_reg   <= err_next;
        num_reg   <= num_next;
        den_reg   <= den_next;
        cnt_reg   <= cnt_next;
        steep_reg <= steep_next;
        fall_reg  <= fall_next;
        color_reg <= color_next;
    end

    assign s_ready       = (state_reg == LPR_IDLE);
    assign m_valid       = (state_reg == LPR_RUN);
    assign m_pixel_x     = px_reg;
    assign m_pixel_y     = py_reg;
    assign m_pixel_color = color_reg;
    assign m_last_pixel  = (cnt_reg == '0);

`ifndef NO_ASSERTIONS
    // never accepting a line while a pixel is offered
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("s_ready and m_valid high together");

    // error term stays below its denominator while stepping
    a_err_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (err_reg < den_reg || den_reg == '0))
        else $error("error term out of range");

    // an accepted line produces a pixel next cycle
    a_start: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc |=> m_valid)
        else $error("no pixel after line accept");

    // last pixel taken returns to idle
    a_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_acc && m_last_pixel) |=> s_ready)
        else $error("not idle after last pixel");

    // a non-final pixel taken is followed by another pixel
    a_more: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_acc && !m_last_pixel) |=> m_valid)
        else $error("pixel stream ended early");
`endif

endmodule

### bench/testbench.sv
// Self-checking testbench for line_pixel_rasterizer_top: directed and random lines.
module testbench
    import lpr_pkg::*;
;

    localparam int COORD_W   = COORD_BITS_DEF;
    localparam int COORD_MAX = (1 << COORD_W) - 1;

    // One expected pixel word
    typedef struct {
        logic [COORD_W-1:0]    x;
        logic [COORD_W-1:0]    y;
        logic [COLOR_BITS-1:0] color;
        logic                  last;
    } pixel_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    logic [COORD_W-1:0]    s_x_start;
    logic [COORD_W-1:0]    s_y_start;
    logic [COORD_W-1:0]    s_x_end;
    logic [COORD_W-1:0]    s_y_end;
    logic [COLOR_BITS-1:0] s_line_color;
    logic                  m_valid;
    logic                  m_ready;
    logic [COORD_W-1:0]    m_pixel_x;
    logic [COORD_W-1:0]    m_pixel_y;
    logic [COLOR_BITS-1:0] m_pixel_color;
    logic                  m_last_pixel;

    pixel_t pixels_due[$];
    int     lines_sent;
    int     pixels_seen;
    int     error_count;
    bit     idle_on;

    line_pixel_rasterizer_top #(
        .COORD_BITS(COORD_W)
    ) DUT (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_x_start(s_x_start),
        .s_y_start(s_y_start),
        .s_x_end(s_x_end),
        .s_y_end(s_y_end),
        .s_line_color(s_line_color),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_pixel_x(m_pixel_x),
        .m_pixel_y(m_pixel_y),
        .m_pixel_color(m_pixel_color),
        .m_last_pixel(m_last_pixel)
    );

    // Clock
    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Safety net against a hung handshake
    initial begin
        #7_000_000;
        $display("%0t: timeout, %0d pixels still due", $time, pixels_due.size());
        $display("FAIL line_pixel_rasterizer_top");
        $finish;
    end

    // Idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        if (!idle_on) return 0;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    // Expected pixels of one line, exact rational floor per axis
    function automatic void predict_line(int xa, int ya, int xb, int yb,
                                         logic [COLOR_BITS-1:0] color);
        int     tmp, dx, ady, lo, hi, n, t, px, py, d;
        bit     fall;
        pixel_t p;
        // order endpoints so that x rises
        if (xb < xa) begin
            tmp = xa; xa = xb; xb = tmp;
            tmp = ya; ya = yb; yb = tmp;
        end
        dx   = xb - xa;
        fall = (yb < ya);
        ady  = fall ? ya - yb : yb - ya;
        lo   = fall ? yb : ya;
        hi   = fall ? ya : yb;
        n    = (ady <= dx) ? dx + 1 : hi - lo + 1;
        for (t = 0; t < n; t++) begin
            if (ady == 0) begin
                px = xa + t;
                py = ya;
            end else if (dx == 0) begin
                px = xa;
                py = lo + t;
            end else if (ady <= dx) begin
                // shallow: falling side rounds the offset up so y stays a floor
                px = xa + t;
                py = fall ? ya - (ady * t + dx - 1) / dx : ya + (ady * t) / dx;
            end else begin
                // steep: walk rows upward
                py = lo + t;
                d  = fall ? ya - py : py - ya;
                px = xa + (dx * d) / ady;
            end
            p.x     = px[COORD_W-1:0];
            p.y     = py[COORD_W-1:0];
            p.color = color;
            p.last  = (t == n - 1);
            pixels_due.push_back(p);
        end
    endfunction

    // Offer one line word, hold it until accepted, then log its pixels
    task automatic send_line(int xa, int ya, int xb, int yb, logic [COLOR_BITS-1:0] color);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid      <= 1'b1;
        s_x_start    <= xa[COORD_W-1:0];
        s_y_start    <= ya[COORD_W-1:0];
        s_x_end      <= xb[COORD_W-1:0];
        s_y_end      <= yb[COORD_W-1:0];
        s_line_color <= color;
        do @(posedge aclk); while (!s_ready);
        predict_line(xa, ya, xb, yb, color);
        lines_sent++;
    endtask

    function automatic logic [COLOR_BITS-1:0] pick_color();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return '0;
        if (r == 1) return '1;
        return COLOR_BITS'($urandom);
    endfunction

    function automatic int clamp_coord(int v);
        if (v < 0) return 0;
        if (v > COORD_MAX) return COORD_MAX;
        return v;
    endfunction

    // Random line drawn from a mix of shapes
    task automatic send_random_line();
        int r, k, xa, ya, xb, yb, tmp;
        r  = $urandom_range(0, 9);
        xa = $urandom_range(0, COORD_MAX);
        ya = $urandom_range(0, COORD_MAX);
        xb = $urandom_range(0, COORD_MAX);
        yb = $urandom_range(0, COORD_MAX);
        case (r)
            0: yb = ya;
            1: xb = xa;
            2: begin
                xb = xa;
                yb = ya;
            end
            3: begin
                // exact diagonal, rising or falling
                k  = $urandom_range(0, COORD_MAX);
                xa = $urandom_range(0, COORD_MAX - k);
                xb = xa + k;
                if ($urandom_range(0, 1)) begin
                    ya = $urandom_range(0, COORD_MAX - k);
                    yb = ya + k;
                end else begin
                    ya = $urandom_range(k, COORD_MAX);
                    yb = ya - k;
                end
            end
            4, 5: begin
                // short line near the first endpoint
                xb = clamp_coord(xa + int'($urandom_range(0, 14)) - 7);
                yb = clamp_coord(ya + int'($urandom_range(0, 14)) - 7);
            end
            default: ;
        endcase
        if ($urandom_range(0, 1)) begin
            tmp = xa; xa = xb; xb = tmp;
            tmp = ya; ya = yb; yb = tmp;
        end
        send_line(xa, ya, xb, yb, pick_color());
    endtask

    // Pixel channel back-pressure
    initial begin
        int n;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            m_ready <= 1'b1;
            repeat ($urandom_range(0, 15)) @(negedge aclk);
            n = pick_gap();
            if (n > 0) begin
                @(negedge aclk);
                m_ready <= 1'b0;
                repeat (n - 1) @(negedge aclk);
            end
        end
    end

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            error_count++;
        end
    endfunction

    // Compare each accepted pixel word with the oldest one due
    always @(posedge aclk) begin : pixel_check
        pixel_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pixels_due.size() == 0) begin
                $display("%0t: unexpected pixel (%0d,%0d) color %0h last %0b", $time,
                         m_pixel_x, m_pixel_y, m_pixel_color, m_last_pixel);
                error_count++;
            end else begin
                want = pixels_due.pop_front();
                check_field("pixel_x", 32'(want.x), 32'(m_pixel_x));
                check_field("pixel_y", 32'(want.y), 32'(m_pixel_y));
                check_field("pixel_color", 32'(want.color), 32'(m_pixel_color));
                check_field("last_pixel", 32'(want.last), 32'(m_last_pixel));
            end
            pixels_seen++;
        end
    end

    // Corners, full-span lines, every slope class, swapped endpoints
    task automatic test_directed_lines();
        send_line(0, 0, 0, 0, 24'h000000);
        send_line(63, 63, 63, 63, 24'hFFFFFF);
        send_line(0, 0, 63, 0, 24'h123456);
        send_line(63, 63, 0, 63, 24'hABCDEF);
        send_line(0, 0, 0, 63, 24'h0F0F0F);
        // falling vertical, runs from the low row up
        send_line(63, 63, 63, 0, 24'hF0F0F0);
        send_line(0, 0, 63, 63, 24'h800000);
        send_line(0, 63, 63, 0, 24'h000001);
        send_line(0, 10, 63, 20, 24'h00FF00);
        send_line(0, 50, 63, 7, 24'h0000FF);
        send_line(5, 0, 17, 63, 24'hFF0000);
        send_line(2, 63, 40, 0, 24'h7FFFFF);
        send_line(60, 5, 3, 30, 24'hFFFFFE);
        send_line(50, 1, 45, 62, 24'h010203);
        send_line(0, 31, 63, 32, 24'h333333);
        send_line(0, 32, 63, 31, 24'hCCCCCC);
        send_line(31, 0, 32, 63, 24'h555555);
        send_line(32, 0, 31, 63, 24'hAAAAAA);
        send_line(10, 10, 11, 10, 24'h777777);
        send_line(1, 2, 3, 7, 24'hA5A5A5);
        send_line(7, 3, 1, 2, 24'h5A5A5A);
    endtask

    task automatic test_random_lines(int count);
        repeat (count) send_random_line();
    endtask

    // No gaps on either channel
    task automatic test_back_to_back(int count);
        idle_on = 1'b0;
        repeat (count) send_random_line();
        idle_on = 1'b1;
    endtask

    initial begin
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_x_start    = '0;
        s_y_start    = '0;
        s_x_end      = '0;
        s_y_end      = '0;
        s_line_color = '0;
        idle_on      = 1'b1;
        lines_sent   = 0;
        pixels_seen  = 0;
        error_count  = 0;
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;

        test_directed_lines();
        test_random_lines(200);
        test_back_to_back(50);
        test_random_lines(50);

        @(negedge aclk);
        s_valid <= 1'b0;
        while (pixels_due.size() > 0) @(posedge aclk);
        repeat (10) @(posedge aclk);

        $display("Drew %0d lines (directed shapes, random mixes, back-to-back)", lines_sent);
        $display("Checked %0d pixels under random stalls, %0d errors", pixels_seen, error_count);
        if (error_count == 0)
            $display("PASS line_pixel_rasterizer_top");
        else
            $display("FAIL line_pixel_rasterizer_top");
        $finish;
    end

endmodule
